// File: rtl/prd_pkg.sv
// prd_pkg: shared constants and types of the phase residue detector
// used by the channel interfaces and the top level
// no dependencies
`default_nettype none

package prd_pkg;

  // fixed field widths of the stream and configuration beats
  localparam int unsigned PHASE_W   = 16;
  localparam int unsigned COUNT_W   = 23;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 1;

  // defaults for the top level parameters
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;
  localparam int unsigned PHASE_BITS_DEF = 16;

  // frame size after reset
  localparam logic [CFG_W-1:0] FRAME_SIZE_RST = 12'h800;

  // largest residue count, the counter saturates here
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // residue classification of one square
  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_POS  = 2'd1,
    RES_NEG  = 2'd2
  } res_code_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: rtl/prd_intf.sv
// prd channel interfaces: pixel input, residue result and configuration write
// each has a source and a sink modport with valid/ready handshake
// depends on prd_pkg for field widths
`default_nettype none

// wrapped phase pixel stream
interface prd_pix_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [prd_pkg::PHASE_W-1:0]   phase;
  logic                                 masked;

  modport source (output valid, output phase, output masked, input ready);
  modport sink   (input valid, input phase, input masked, output ready);
endinterface

// residue result stream
interface prd_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 square_valid;
  logic [1:0]                           res_code;
  logic [prd_pkg::COUNT_W-1:0]          res_count;
  logic                                 frame_end;

  modport source (output valid, output square_valid, output res_code,
                  output res_count, output frame_end, input ready);
  modport sink   (input valid, input square_valid, input res_code,
                  input res_count, input frame_end, output ready);
endinterface

// configuration register writes
interface prd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [prd_pkg::CFG_IDX_W-1:0]        index;
  logic [prd_pkg::CFG_W-1:0]            data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/prd_ram.sv
// prd_ram: generic simple dual port ram with registered, enabled read
// read returns the old contents when reading and writing one address
// no dependencies
`default_nettype none

module prd_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/phase_residue_detect.sv
// phase_residue_detect: 2x2 loop residue detector on a raster phase stream
// path: an accepted pixel beat passes the first stage and result registers
// throughput: one pixel per cycle while res_o is not held; the line store
//   read is issued at accept; its registered data meets the pixel in stage 1
// reset: asynchronous, clears indices, neighbour pixels, count and handshake
//   state, frame size back to 2048; the line store itself is not cleared
`default_nettype none

module phase_residue_detect #(
  parameter int unsigned MaxWidth  = prd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MaxHeight = prd_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned PhaseBits = prd_pkg::PHASE_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  prd_pix_if.sink    pix_i,
  prd_res_if.source  res_o,
  prd_cfg_if.sink    cfg_i
);

  localparam int unsigned CW = $clog2(MaxWidth);
  localparam int unsigned RW = $clog2(MaxHeight);
  localparam int unsigned PW = PhaseBits + 1;  // phase plus mask bit on top
  localparam int unsigned DW = PhaseBits + 2;  // raw difference width
  localparam int unsigned SW = PhaseBits + 3;  // loop sum width

  localparam logic signed [DW-1:0] Half  = DW'(2 ** (PhaseBits - 1));
  localparam logic signed [DW-1:0] Cycle = DW'(2 ** PhaseBits);

  // wrapped difference a - b, brought into [-half, half]
  function automatic logic signed [DW-1:0] wrap_diff(input logic [PhaseBits-1:0] a,
                                                      input logic [PhaseBits-1:0] b);
    logic signed [DW-1:0] d;
    d = $signed({{2{a[PhaseBits-1]}}, a}) - $signed({{2{b[PhaseBits-1]}}, b});
    if (d > Half) begin
      d = d - Cycle;
    end
    if (d < -Half) begin
      d = d + Cycle;
    end
    return d;
  endfunction

  // configuration registers
  logic [prd_pkg::CFG_W-1:0] width_q, height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= prd_pkg::FRAME_SIZE_RST;
      height_q <= prd_pkg::FRAME_SIZE_RST;
    end else if (cfg_i.valid) begin
      case (prd_pkg::cfg_idx_e'(cfg_i.index))
        prd_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_i.data;
        prd_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // clamped frame size
  logic [31:0] w_eff, h_eff;

  always_comb begin
    if (width_q < prd_pkg::CFG_W'(2)) begin
      w_eff = 32'd2;
    end else if (32'(width_q) > 32'(MaxWidth)) begin
      w_eff = 32'(MaxWidth);
    end else begin
      w_eff = 32'(width_q);
    end
    if (height_q < prd_pkg::CFG_W'(2)) begin
      h_eff = 32'd2;
    end else if (32'(height_q) > 32'(MaxHeight)) begin
      h_eff = 32'(MaxHeight);
    end else begin
      h_eff = 32'(height_q);
    end
  end

  // handshake and stage control
  logic s1_valid_q, out_valid_q;
  logic s1_adv, pix_acc;

  assign s1_adv      = s1_valid_q && (!out_valid_q || res_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign pix_acc     = pix_i.valid && pix_i.ready;

  // raster position
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          col_wrap, row_wrap;
  logic [PW-1:0] cur_px;

  assign col_wrap = (32'(col_q) + 32'd1) >= w_eff;
  assign row_wrap = (32'(row_q) + 32'd1) >= h_eff;
  assign cur_px   = {pix_i.masked, PhaseBits'($unsigned(pix_i.phase))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_acc) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // line store: row above, read and overwritten at the same column on accept
  logic [PW-1:0] above;

  prd_ram #(
    .Width (PW),
    .Depth (MaxWidth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (pix_acc),
    .waddr_i (col_q),
    .wdata_i (cur_px),
    .re_i    (pix_acc),
    .raddr_i (col_q),
    .rdata_o (above)
  );

  // first stage register
  logic [PW-1:0] s1_cur_q;
  logic          s1_geom_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_cur_q  <= cur_px;
      s1_geom_q <= (row_q != '0) && (col_q != '0);
      s1_last_q <= col_wrap && row_wrap;
    end
  end

  // loop sum around the square
  logic [PW-1:0]        left_q, ul_q;
  logic signed [SW-1:0] loop_sum;
  logic                 any_mask, sq_ok;
  prd_pkg::res_code_e   code;

  always_comb begin
    loop_sum = SW'(wrap_diff(above[PhaseBits-1:0], ul_q[PhaseBits-1:0]))
             + SW'(wrap_diff(s1_cur_q[PhaseBits-1:0], above[PhaseBits-1:0]))
             + SW'(wrap_diff(left_q[PhaseBits-1:0], s1_cur_q[PhaseBits-1:0]))
             + SW'(wrap_diff(ul_q[PhaseBits-1:0], left_q[PhaseBits-1:0]));
    any_mask = ul_q[PW-1] | above[PW-1] | left_q[PW-1] | s1_cur_q[PW-1];
    sq_ok    = s1_geom_q && !any_mask;
    if (!sq_ok) begin
      code = prd_pkg::RES_NONE;
    end else if (loop_sum > 0) begin
      code = prd_pkg::RES_POS;
    end else if (loop_sum < 0) begin
      code = prd_pkg::RES_NEG;
    end else begin
      code = prd_pkg::RES_NONE;
    end
  end

  // residue count with saturation
  logic [prd_pkg::COUNT_W-1:0] total_q, total_inc;

  assign total_inc = (code != prd_pkg::RES_NONE && total_q != prd_pkg::COUNT_MAX)
                     ? total_q + 1'b1 : total_q;

  // neighbours and count advance with each beat leaving the first stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      ul_q    <= '0;
      total_q <= '0;
    end else if (s1_adv) begin
      left_q  <= s1_cur_q;
      ul_q    <= above;
      total_q <= s1_last_q ? '0 : total_inc;
    end
  end

  // result register
  logic                        out_sq_q, out_end_q;
  prd_pkg::res_code_e          out_code_q;
  logic [prd_pkg::COUNT_W-1:0] out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_sq_q    <= sq_ok;
      out_code_q  <= code;
      out_count_q <= total_inc;
      out_end_q   <= s1_last_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.square_valid = out_sq_q;
  assign res_o.res_code     = out_code_q;
  assign res_o.res_count    = out_count_q;
  assign res_o.frame_end    = out_end_q;

`ifndef SYNTHESIS
  // an unchecked square never carries a residue
  a_no_code_unchecked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.square_valid) |-> (res_o.res_code == prd_pkg::RES_NONE))
    else $error("residue reported on an unchecked square");

  // the input only stalls when both stages are full and the output is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (s1_valid_q && out_valid_q && !res_o.ready))
    else $error("input stalled without a full pipeline");

  // the count restarts after the last pixel of a frame
  a_count_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (total_q == '0))
    else $error("residue count not cleared at frame end");
`endif

endmodule

`default_nettype wire
